>>> sv/cmac_pkg.sv
package cmac_pkg;

	localparam int BlockBytes = 16;
	localparam int FillW = $clog2(BlockBytes);
	localparam int RoundW = 4;
	localparam logic [RoundW-1:0] LastRound = 4'd10;

	typedef enum logic [1:0] {
		OP_ABSORB   = 2'd0,
		OP_FINALIZE = 2'd1,
		OP_RESTART  = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic done;
	} aes_ctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r=8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

>>> sv/cmac_aes_core.sv
module cmac_aes_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmac_pkg::aes_ctl_t   ctl_in,
	output cmac_pkg::aes_ctl_t   ctl_out,
	input  logic [127:0]         key,
	input  logic [127:0]         din,
	output logic [127:0]         dout
);
	import cmac_pkg::*;

	logic [127:0] st_q, rk_q;
	logic [RoundW-1:0] rnd_q;
	logic [7:0] rcon_q;
	logic busy_q, done_q;
	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] k [16];
	logic [7:0] nk [16];
	logic [127:0] nxt_st, nxt_rk;

	// byte i sits in bits 127-8i
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = st_q[127-8*i -: 8];
			k[i] = rk_q[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i+4*c] = sbox(s[i + 4*((c+i) & 3)]);
		for (int c = 0; c < 4; c++) begin
			m[4*c]   = t[4*c]   ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xt(t[4*c]^t[4*c+1]);
			m[4*c+1] = t[4*c+1] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xt(t[4*c+1]^t[4*c+2]);
			m[4*c+2] = t[4*c+2] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xt(t[4*c+2]^t[4*c+3]);
			m[4*c+3] = t[4*c+3] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xt(t[4*c+3]^t[4*c]);
		end
		nk[0] = k[0] ^ sbox(k[13]) ^ rcon_q;
		nk[1] = k[1] ^ sbox(k[14]);
		nk[2] = k[2] ^ sbox(k[15]);
		nk[3] = k[3] ^ sbox(k[12]);
		for (int i = 4; i < 16; i++)
			nk[i] = k[i] ^ nk[i-4];
		for (int i = 0; i < 16; i++) begin
			nxt_rk[127-8*i -: 8] = nk[i];
			nxt_st[127-8*i -: 8] = (rnd_q == LastRound ? t[i] : m[i]) ^ nk[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				rnd_q  <= RoundW'(1);
			end else if (busy_q) begin
				rnd_q <= rnd_q + RoundW'(1);
				if (rnd_q == LastRound) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			st_q   <= din ^ key;
			rk_q   <= key;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			st_q   <= nxt_st;
			rk_q   <= nxt_rk;
			rcon_q <= xt(rcon_q);
		end
	end

	assign dout = st_q;
	assign ctl_out.start = busy_q;
	assign ctl_out.done = done_q;
endmodule

>>> sv/cbc_mac_aes128_top.sv
// channel  direction  handshake       payload
// in       input      valid / stall   operation, data_byte
// out      output     valid / stall   tag_high, tag_low
// cfg      input      cfg_we          cfg_index, cfg_data
// absorb folds a byte into the chaining word; the 16th byte of a block also starts the aes rounds
// finalize on a partial block encrypts the chaining word before the output wait, else the chaining word is the tag
// one shared round unit does every encryption; in_stall stays high while busy
// reset clears key, chaining word and fill count
// out_valid holds with a steady tag until out_stall drops
module cbc_mac_aes128_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] tag_high,
	output logic [63:0] tag_low,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	import cmac_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ENC  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [127:0] key_q, chain_q, tag_q;
	logic [127:0] chain_mix;
	logic [FillW-1:0] fill_q;
	aes_ctl_t ctl_in, ctl_out;
	logic [127:0] aes_out;
	logic acc;
	op_t op;

	cmac_aes_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl_in(ctl_in), .ctl_out(ctl_out),
		.key(key_q), .din(chain_mix), .dout(aes_out)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign acc = in_valid && !in_stall;
	assign op = op_t'(operation);
	assign out_valid = (state_q == ST_OUT);
	assign tag_high = tag_q[127:64];
	assign tag_low = tag_q[63:0];

	// chaining word with the incoming byte folded in on an absorb
	always_comb begin
		chain_mix = chain_q;
		if (op == OP_ABSORB)
			chain_mix[127-8*fill_q -: 8] = chain_q[127-8*fill_q -: 8] ^ data_byte;
	end

	always_comb begin
		ctl_in.done = 1'b0;
		ctl_in.start = 1'b0;
		if (acc) begin
			if (op == OP_ABSORB && fill_q == FillW'(BlockBytes-1))
				ctl_in.start = 1'b1;
			if (op == OP_FINALIZE && fill_q != '0)
				ctl_in.start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q   <= '0;
			chain_q <= '0;
			fill_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_KEY_HIGH: key_q[127:64] <= cfg_data;
					REG_KEY_LOW:  key_q[63:0] <= cfg_data;
					default: ;
				endcase
				chain_q <= '0;
				fill_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (op)
							OP_ABSORB: begin
								chain_q <= chain_mix;
								fill_q <= fill_q + FillW'(1);
								if (fill_q == FillW'(BlockBytes-1))
									state_q <= ST_ENC;
							end
							OP_FINALIZE: state_q <= (fill_q != '0) ? ST_FIN : ST_OUT;
							OP_RESTART: begin
								chain_q <= '0;
								fill_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_ENC: if (ctl_out.done) begin
					chain_q <= aes_out;
					state_q <= ST_IDLE;
				end
				ST_FIN: if (ctl_out.done) state_q <= ST_OUT;
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc && op == OP_FINALIZE && fill_q == '0)
			tag_q <= chain_q;
		else if (state_q == ST_FIN && ctl_out.done)
			tag_q <= aes_out;
	end
endmodule

>>> verif/tb_top.sv
module tb_top;
	import cmac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;
	localparam int NumWords = 850;

	typedef struct {
		op_t        op;
		logic [7:0] data;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] tag_high;
	logic [63:0] tag_low;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;

	cbc_mac_aes128_top uut (.*);

	word_t        pending_words[$];
	logic [127:0] tag_q[$];
	logic [7:0]   sub_tab[256];
	logic [127:0] mac_key;
	logic [127:0] chain_word;
	int           fill;
	int           errors;
	int           cycles;
	int           burst_left;
	int           gap_left;
	int           stall_mode;
	int           word_count;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [127:0] enc_block(input logic [127:0] pt, input logic [127:0] k);
		logic [7:0] s[16];
		logic [7:0] t[16];
		logic [7:0] rk[16];
		logic [7:0] rc;
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] ct;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			rk[i] = k[127-8*i -: 8];
			s[i] = pt[127-8*i -: 8] ^ rk[i];
		end
		for (int r = 1; r <= 10; r++) begin
			rk[0] ^= sub_tab[rk[13]] ^ rc;
			rk[1] ^= sub_tab[rk[14]];
			rk[2] ^= sub_tab[rk[15]];
			rk[3] ^= sub_tab[rk[12]];
			for (int i = 4; i < 16; i++)
				rk[i] ^= rk[i-4];
			rc = gmul(rc, 8'h02);
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[i+4*c] = sub_tab[s[i + 4*((c+i) % 4)]];
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ all ^ gmul(a0 ^ a1, 8'h02);
					t[4*c+1] = a1 ^ all ^ gmul(a1 ^ a2, 8'h02);
					t[4*c+2] = a2 ^ all ^ gmul(a2 ^ a3, 8'h02);
					t[4*c+3] = a3 ^ all ^ gmul(a3 ^ a0, 8'h02);
				end
			end
			for (int i = 0; i < 16; i++)
				s[i] = t[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++)
			ct[127-8*i -: 8] = s[i];
		return ct;
	endfunction

	task automatic mac_step(input word_t w);
		case (w.op)
			OP_ABSORB: begin
				chain_word[127-8*fill -: 8] ^= w.data;
				fill++;
				if (fill == BlockBytes) begin
					chain_word = enc_block(chain_word, mac_key);
					fill = 0;
				end
			end
			OP_FINALIZE:
				tag_q.push_back(fill != 0 ? enc_block(chain_word, mac_key) : chain_word);
			OP_RESTART: begin
				chain_word = '0;
				fill = 0;
			end
			default: ;
		endcase
	endtask

	task automatic push_word(input op_t op, input logic [7:0] d);
		word_t w;
		w.op = op;
		w.data = d;
		pending_words.push_back(w);
		if (op != OP_NONE)
			word_count++;
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || tag_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_key(input reg_idx_t idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_HIGH)
			mac_key[127:64] = v;
		else
			mac_key[63:0] = v;
		chain_word = '0;
		fill = 0;
	endtask

	// sender: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_NONE;
			data_byte <= 8'h00;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				mac_step('{op_t'(operation), data_byte});
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || pending_words.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0)
						gap_left <= gap_left - 1;
				end else begin
					in_valid <= 1'b1;
					operation <= pending_words[0].op;
					data_byte <= pending_words[0].data;
					void'(pending_words.pop_front());
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// receiver stall pattern and tag check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
		end else begin
			if (cycles % 97 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 9) != 0);
				default: out_stall <= ((cycles / 7) % 2 == 0);
			endcase
			if (out_valid && !out_stall) begin
				if (tag_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected tag %h_%h", tag_high, tag_low);
				end else begin
					if (tag_high !== tag_q[0][127:64] || tag_low !== tag_q[0][63:0]) begin
						errors++;
						if (errors <= 10)
							$display("tag mismatch: expected %h actual %h_%h",
								tag_q[0], tag_high, tag_low);
					end
					void'(tag_q.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int len;
		logic [63:0] kh, kl;
		cycles = 0;
		errors = 0;
		word_count = 0;
		mac_key = '0;
		chain_word = '0;
		fill = 0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		for (int a = 0; a < 256; a++) begin
			logic [7:0] inv, b;
			inv = 8'h00;
			for (int x = 1; x < 256; x++)
				if (gmul(a[7:0], x[7:0]) == 8'h01)
					inv = x[7:0];
			b = inv;
			sub_tab[a] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ 8'h63;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset key
		push_word(OP_FINALIZE, 8'h00);
		push_word(OP_ABSORB, 8'h00);
		push_word(OP_ABSORB, 8'hff);
		push_word(OP_FINALIZE, 8'h55);
		push_word(OP_NONE, 8'haa);
		for (int i = 0; i < 14; i++)
			push_word(OP_ABSORB, i[0] ? 8'hff : 8'h00);
		push_word(OP_FINALIZE, 8'hff);
		push_word(OP_RESTART, 8'hff);
		push_word(OP_FINALIZE, 8'h00);
		wait_idle();

		for (int phase = 0; word_count < NumWords; phase++) begin
			case (phase)
				0: begin kh = '1; kl = '1; end
				1: begin kh = '0; kl = '1; end
				2: begin kh = '1; kl = '0; end
				default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
			endcase
			write_key(REG_KEY_HIGH, kh);
			write_key(REG_KEY_LOW, kl);
			while (word_count < NumWords && word_count % 140 < 130) begin
				case ($urandom_range(0, 9))
					0: push_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
					1: push_word(OP_RESTART, 8'($urandom_range(0, 255)));
					default: begin
						len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 48)
							: $urandom_range(0, 20);
						for (int i = 0; i < len; i++) begin
							push_word(OP_ABSORB, 8'($urandom_range(0, 255)));
							if ($urandom_range(0, 15) == 0)
								push_word(OP_FINALIZE, 8'($urandom_range(0, 255)));
						end
						push_word(OP_FINALIZE, 8'($urandom_range(0, 255)));
						if ($urandom_range(0, 1) == 0)
							push_word(OP_RESTART, 8'($urandom_range(0, 255)));
					end
				endcase
			end
			wait_idle();
			if (word_count % 140 >= 130)
				word_count += 140 - word_count % 140;
		end

		wait_idle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
sv/cmac_pkg.sv
sv/cmac_aes_core.sv
sv/cbc_mac_aes128_top.sv
verif/tb_top.sv
